FILE: rtl/core/lwkz_pkg.sv
// ----------------------------------------------------------------------------
// lwkz_pkg
// Shared types and constants for the longest window with at most k zeros block.
// ----------------------------------------------------------------------------
`default_nettype none

package lwkz_pkg;

	// Sequence positions, one-based, up to MAX_LENGTH
	localparam int unsigned POS_W      = 17;
	localparam int unsigned MAX_LENGTH = 65536;

	// Window length arithmetic, one bit above a position
	localparam int unsigned LEN_W = POS_W + 1;

	// Zero position queue
	localparam int unsigned Q_DEPTH = 256;
	localparam int unsigned Q_AW    = $clog2(Q_DEPTH);

	// Zero count in window (holds up to Q_DEPTH)
	localparam int unsigned ZCNT_W = Q_AW + 1;

	// Configuration port
	localparam int unsigned LIMIT_W    = 8;
	localparam int unsigned CFG_ADDR_W = 3;
	localparam int unsigned CFG_DATA_W = 32;

	typedef logic [POS_W-1:0]   pos_t;
	typedef logic [Q_AW-1:0]    qptr_t;
	typedef logic [ZCNT_W-1:0]  zcnt_t;
	typedef logic [LIMIT_W-1:0] limit_t;

	// Register indexes (word address = byte address / 4)
	typedef enum logic [CFG_ADDR_W-3:0] {
		REG_MAX_ZEROS = 1'b0
	} reg_idx_t;

	// Largest limit the queue can carry
	localparam zcnt_t QUEUE_LIMIT = zcnt_t'(Q_DEPTH - 1);

endpackage : lwkz_pkg

`default_nettype wire

FILE: rtl/core/lwkz_ram.sv
// ----------------------------------------------------------------------------
// lwkz_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lwkz_ram #(
	parameter int unsigned WIDTH = 17,
	parameter int unsigned DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read (old data on a same-address collision)
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule : lwkz_ram

`default_nettype wire

FILE: rtl/core/longest_window_at_most_k_zeros.sv
// ----------------------------------------------------------------------------
// longest_window_at_most_k_zeros
// Sliding-window search for the longest run of bits holding at most
// max_zeros zeros; zero positions are kept in a RAM-based FIFO.
// ----------------------------------------------------------------------------
//
//   port group   direction  handshake         payload
//   -----------  ---------  ----------------  ------------------------------
//   input        in         in_valid/in_ready bit_value, is_last
//   result       out        out_valid/out_ready found, window_start, window_end
//   config       in/out     psel/penable      paddr, pwdata, prdata (APB)
//
// One request per cycle, but for the is_last hold-off below. The pointer
// and best-window registers update in the accept cycle; the queue head is
// prefetched from the RAM, with a bypass for a write to the entry being read.
// A result sits in a one-entry output register; a request with is_last is
// held off only while that register is full and not being drained.
// Reset is immediate: the queue RAM needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module longest_window_at_most_k_zeros (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// input requests
	input  wire logic                                in_valid,
	output      logic                                in_ready,
	input  wire logic                                bit_value,
	input  wire logic                                is_last,
	// results
	output      logic                                out_valid,
	input  wire logic                                out_ready,
	output      logic                                found,
	output      logic [lwkz_pkg::POS_W-1:0]          window_start,
	output      logic [lwkz_pkg::POS_W-1:0]          window_end,
	// configuration
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic [lwkz_pkg::CFG_ADDR_W-1:0]     paddr,
	input  wire logic [lwkz_pkg::CFG_DATA_W-1:0]     pwdata,
	output      logic [lwkz_pkg::CFG_DATA_W-1:0]     prdata,
	output      logic                                pready
);

	// Configuration
	lwkz_pkg::limit_t max_zeros_q;
	lwkz_pkg::reg_idx_t reg_idx;

	// Sequence state
	lwkz_pkg::pos_t  pos_q, left_q, best_len_q, best_start_q, best_end_q;
	lwkz_pkg::zcnt_t zeros_q;
	lwkz_pkg::qptr_t head_q, tail_q;

	// Queue RAM access
	logic            q_we;
	lwkz_pkg::qptr_t q_raddr;
	lwkz_pkg::pos_t  q_rdata;
	logic            fwd_hit_s1;
	lwkz_pkg::pos_t  fwd_data_s1;
	lwkz_pkg::pos_t  head_val;

	// Step logic
	logic            in_acc, out_acc, advance, push, pop, clear;
	lwkz_pkg::zcnt_t limit, zeros_push, zeros_d;
	lwkz_pkg::pos_t  pos_d, left_d, popped;
	lwkz_pkg::pos_t  best_len_d, best_start_d, best_end_d;
	lwkz_pkg::qptr_t head_d, tail_d;
	logic [lwkz_pkg::LEN_W-1:0] right_ext, left_ext, len;

	// Output register
	logic           out_valid_q, found_q;
	lwkz_pkg::pos_t start_q, end_q;

	// ------------------------------------------------------------------
	// APB register port
	// ------------------------------------------------------------------
	assign reg_idx = lwkz_pkg::reg_idx_t'(paddr[lwkz_pkg::CFG_ADDR_W-1:2]);
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_zeros_q <= '0;
		end else if (psel && penable && pwrite && reg_idx == lwkz_pkg::REG_MAX_ZEROS) begin
			max_zeros_q <= pwdata[lwkz_pkg::LIMIT_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_idx == lwkz_pkg::REG_MAX_ZEROS) begin
			prdata = lwkz_pkg::CFG_DATA_W'(max_zeros_q);
		end
	end

	// ------------------------------------------------------------------
	// Handshakes
	// ------------------------------------------------------------------
	assign out_acc  = out_valid_q && out_ready;
	assign in_ready = !is_last || !out_valid_q || out_ready;
	assign in_acc   = in_valid && in_ready;

	// ------------------------------------------------------------------
	// Window step
	// ------------------------------------------------------------------
	// Head entry: bypass a write that landed on the prefetched address
	assign head_val = fwd_hit_s1 ? fwd_data_s1 : q_rdata;

	always_comb begin
		limit = (lwkz_pkg::zcnt_t'(max_zeros_q) > lwkz_pkg::QUEUE_LIMIT)
			? lwkz_pkg::QUEUE_LIMIT : lwkz_pkg::zcnt_t'(max_zeros_q);

		advance = in_acc && (pos_q < lwkz_pkg::pos_t'(lwkz_pkg::MAX_LENGTH));
		clear   = in_acc && is_last;

		pos_d = advance ? pos_q + 1'b1 : pos_q;
		push  = advance && !bit_value;

		zeros_push = push ? zeros_q + 1'b1 : zeros_q;
		pop        = advance && (zeros_push > limit);
		zeros_d    = pop ? zeros_push - 1'b1 : zeros_push;

		// Empty queue: the zero being pushed is the one popped
		popped = (zeros_q == '0) ? pos_d : head_val;
		left_d = pop ? popped + 1'b1 : left_q;

		tail_d = push ? tail_q + 1'b1 : tail_q;
		head_d = pop ? head_q + 1'b1 : head_q;

		// Window length, zero when left edge is past the right edge
		right_ext = lwkz_pkg::LEN_W'(pos_d) + 1'b1;
		left_ext  = lwkz_pkg::LEN_W'(left_d);
		len       = (right_ext >= left_ext) ? right_ext - left_ext : '0;

		best_len_d   = best_len_q;
		best_start_d = best_start_q;
		best_end_d   = best_end_q;
		if (advance && len > lwkz_pkg::LEN_W'(best_len_q)) begin
			best_len_d   = len[lwkz_pkg::POS_W-1:0];
			best_start_d = left_d;
			best_end_d   = pos_d;
		end
	end

	// Sequence registers; a last request restores the reset state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			left_q       <= lwkz_pkg::pos_t'(1);
			zeros_q      <= '0;
			best_len_q   <= '0;
			best_start_q <= '0;
			best_end_q   <= '0;
			head_q       <= '0;
			tail_q       <= '0;
		end else if (clear) begin
			pos_q        <= '0;
			left_q       <= lwkz_pkg::pos_t'(1);
			zeros_q      <= '0;
			best_len_q   <= '0;
			best_start_q <= '0;
			best_end_q   <= '0;
			head_q       <= '0;
			tail_q       <= '0;
		end else if (advance) begin
			pos_q        <= pos_d;
			left_q       <= left_d;
			zeros_q      <= zeros_d;
			best_len_q   <= best_len_d;
			best_start_q <= best_start_d;
			best_end_q   <= best_end_d;
			head_q       <= head_d;
			tail_q       <= tail_d;
		end
	end

	// ------------------------------------------------------------------
	// Zero position queue
	// ------------------------------------------------------------------
	assign q_we    = push;
	assign q_raddr = clear ? '0 : head_d;

	lwkz_ram #(
		.WIDTH (lwkz_pkg::POS_W),
		.DEPTH (lwkz_pkg::Q_DEPTH)
	) u_zero_queue (
		.clk   (clk),
		.we    (q_we),
		.waddr (tail_q),
		.wdata (pos_d),
		.raddr (q_raddr),
		.rdata (q_rdata)
	);

	// Same-cycle write to the entry being prefetched
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_hit_s1 <= 1'b0;
		end else begin
			fwd_hit_s1 <= q_we && (tail_q == q_raddr);
		end
	end

	always_ff @(posedge clk) begin
		fwd_data_s1 <= pos_d;
	end

	// ------------------------------------------------------------------
	// Result register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (clear) begin
			out_valid_q <= 1'b1;
		end else if (out_acc) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (clear) begin
			found_q <= (best_len_d != '0);
			start_q <= (best_len_d != '0) ? best_start_d : '0;
			end_q   <= (best_len_d != '0) ? best_end_d : '0;
		end
	end

	assign out_valid    = out_valid_q;
	assign found        = found_q;
	assign window_start = start_q;
	assign window_end   = end_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	// Queue occupancy tracks the zero count
	a_occupancy: assert property (@(posedge clk) disable iff (!arst_n)
		(tail_q - head_q) == zeros_q[lwkz_pkg::Q_AW-1:0])
		else $error("queue pointers disagree with zero count");

	// Zero count never exceeds what the queue can hold
	a_zero_bound: assert property (@(posedge clk) disable iff (!arst_n)
		zeros_q <= lwkz_pkg::QUEUE_LIMIT)
		else $error("zero count above queue capacity");

	// A missing window reports zero positions
	a_not_found: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !found_q |-> start_q == '0 && end_q == '0)
		else $error("empty result with nonzero positions");

	// A found window is well formed
	a_found_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && found_q |-> start_q != '0 && start_q <= end_q)
		else $error("malformed window in result");

	// Best window never shrinks within a sequence
	a_best_grows: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !clear |=> best_len_q >= $past(best_len_q))
		else $error("best length decreased");

endmodule : longest_window_at_most_k_zeros

`default_nettype wire
